// File: rtl/gcd_pkg.sv
// Shared constants, types and elaboration-time table functions for the
// great-circle distance block. No dependencies.
package gcd_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int FRAC_BITS_DEF = 30;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ISQRT_STEPS = 32;
	localparam int VEC_W = 36;
	localparam int ZQ_W = 33;
	localparam int RADIUS_W = 23;
	localparam int DIST_W = 25;

	localparam logic signed [31:0] LAT_LIMIT = 32'sh4000_0000;
	localparam logic signed [63:0] PI_Q28 = 64'sd843314857;
	localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90_FDAA_2216_8C23;
	localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921_FB54_442D_1847;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

	typedef struct packed {
		logic signed [32:0] dlat;
		logic signed [31:0] dlon;
		logic signed [31:0] lat_a;
		logic signed [31:0] lat_b;
	} queue_item_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} queue_status_t;

	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		int          b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] rem;
		logic [63:0] bt;
		int          j;
		r = '0;
		rem = v;
		bt = 64'd1 << 62;
		for (j = 0; j < ISQRT_STEPS; j++) begin
			if (rem >= r + bt) begin
				rem = rem - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] atan_q60(input int idx);
		logic signed [63:0] sum;
		logic [63:0]        term;
		int                 k;
		int                 e;
		sum = '0;
		if (idx == 0) begin
			return QUARTER_PI_Q60;
		end
		for (k = 0; idx * (2 * k + 1) <= 62; k++) begin
			e = 62 - idx * (2 * k + 1);
			term = div_u64(64'd1 << e, 64'(2 * k + 1));
			if (k[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		return (sum + 64'sd2) >>> 2;
	endfunction

	function automatic logic [63:0] gain_inv(input int steps, input int frac);
		logic [63:0] g;
		logic [63:0] s;
		logic [63:0] q;
		logic [63:0] r;
		int          i;
		g = 64'd1 << 60;
		for (i = 0; i < steps; i++) begin
			if (2 * i < 64) begin
				g = g + (g >> (2 * i));
			end
		end
		s = isqrt_u64(g);
		q = div_u64(64'd1 << 30, s);
		r = (64'd1 << 30) - q * s;
		for (i = 0; i < frac; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= s) begin
				r = r - s;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

endpackage

// File: rtl/great_circle_distance.sv
// Top level of the great-circle distance block; holds the radius register.
// Depends on gcd_pkg, gcd_front, gcd_queue and gcd_back.
//
// Usage: a transaction carries two points (lat_a, lon_a, lat_b, lon_b) as
// signed binary angles where 2^31 stands for 180 degrees. It is accepted at a
// rising edge with start high and busy low. The result distance_m, in whole
// meters, is shown for exactly one cycle with done high; the receiver must take
// it then, since it cannot hold results off.
// The stages are a clamping register, the queue, the angle multiply, the rotation
// CORDIC, the product and sum stages, the 32-stage square root, the vectoring
// CORDIC and two scaling stages. Throughput is one transaction per cycle; every
// unit is fully pipelined and the queue drains every cycle, so busy stays low in
// steady use. The radius register is written by cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset clears the pipeline valid bits and the queue and loads the radius with
// 6371000; no clearing pass is needed.
module great_circle_distance
	import gcd_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  lat_a,
	input  logic signed [31:0]  lon_a,
	input  logic signed [31:0]  lat_b,
	input  logic signed [31:0]  lon_b,
	input  logic                cfg_we,
	input  logic [RADIUS_W-1:0] cfg_wdata,
	output logic                done,
	output logic [DIST_W-1:0]   distance_m
);

	logic [RADIUS_W-1:0] radius_q;
	queue_status_t       status;
	queue_item_t         push_item;
	queue_item_t         pop_item;
	logic                push;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	gcd_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.status(status), .push(push), .push_item(push_item)
	);

	gcd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .pop_item(pop_item), .status(status)
	);

	gcd_back #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .status(status), .pop_item(pop_item),
		.pop(pop), .radius(radius_q), .done(done), .distance_m(distance_m)
	);

endmodule

// File: rtl/gcd_front.sv
// Front end: accepts point pairs, clamps latitudes and forms the differences.
// Depends on gcd_pkg; feeds gcd_queue.
module gcd_front
	import gcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  lat_a,
	input  logic signed [31:0]  lon_a,
	input  logic signed [31:0]  lat_b,
	input  logic signed [31:0]  lon_b,
	input  queue_status_t       status,
	output logic                push,
	output queue_item_t         push_item
);

	logic               accept;
	logic signed [31:0] la;
	logic signed [31:0] lb;
	logic               valid_s1;
	queue_item_t        item_s1;

	function automatic logic signed [31:0] clamp_lat(input logic signed [31:0] v);
		if (v > LAT_LIMIT) begin
			return LAT_LIMIT;
		end else if (v < -LAT_LIMIT) begin
			return -LAT_LIMIT;
		end
		return v;
	endfunction

	assign busy = ({1'b0, status.count} + (QCNT_W + 1)'(valid_s1))
		>= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = start && !busy;
	assign la = clamp_lat(lat_a);
	assign lb = clamp_lat(lat_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.dlat <= 33'(lb) - 33'(la);
			item_s1.dlon <= lon_b - lon_a;
			item_s1.lat_a <= la;
			item_s1.lat_b <= lb;
		end
	end

	assign push = valid_s1;
	assign push_item = item_s1;

	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(status.empty && !valid_s1) |-> !busy)
		else $error("Front end busy with nothing in flight.");

endmodule

// File: rtl/gcd_queue.sv
// Short register queue between the front end and the arithmetic back end.
// Depends on gcd_pkg.
module gcd_queue
	import gcd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  queue_item_t   push_item,
	input  logic          pop,
	output queue_item_t   pop_item,
	output queue_status_t status
);

	queue_item_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item = mem_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QUEUE_DEPTH) || pop))
		else $error("Transaction pushed into a full queue.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("Transaction popped from an empty queue.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("Queue count beyond its depth.");

endmodule

// File: rtl/gcd_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, in rotation or vectoring mode.
// Depends on gcd_pkg for the arctangent table.
module gcd_cordic
	import gcd_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF,
	parameter int XW = FRAC_BITS_DEF + 3,
	parameter bit VECTORING = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [63:0]   in_z,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [63:0]   out_z
);

	logic signed [XW-1:0] x_s [1:STEPS];
	logic signed [XW-1:0] y_s [1:STEPS];
	logic signed [63:0]   z_s [1:STEPS];
	logic                 v_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [63:0] ATAN = atan_q60(i);
		logic signed [XW-1:0] cx;
		logic signed [XW-1:0] cy;
		logic signed [63:0]   cz;
		logic                 cv;
		logic                 pos;

		if (i == 0) begin : g_first
			assign cx = in_x;
			assign cy = in_y;
			assign cz = in_z;
			assign cv = in_valid;
		end else begin : g_next
			assign cx = x_s[i];
			assign cy = y_s[i];
			assign cz = z_s[i];
			assign cv = v_s[i];
		end

		assign pos = VECTORING ? (cy < 0) : (cz >= 0);

		always_ff @(posedge clk) begin
			if (pos) begin
				x_s[i+1] <= cx - (cy >>> i);
				y_s[i+1] <= cy + (cx >>> i);
				z_s[i+1] <= cz - ATAN;
			end else begin
				x_s[i+1] <= cx + (cy >>> i);
				y_s[i+1] <= cy - (cx >>> i);
				z_s[i+1] <= cz + ATAN;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= cv;
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_x = x_s[STEPS];
	assign out_y = y_s[STEPS];
	assign out_z = z_s[STEPS];

endmodule

// File: rtl/gcd_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on gcd_pkg.
module gcd_isqrt
	import gcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] in_value,
	output logic        out_valid,
	output logic [31:0] out_root
);

	logic [63:0] v_s [1:ISQRT_STEPS];
	logic [63:0] r_s [1:ISQRT_STEPS];
	logic        ok_s [1:ISQRT_STEPS];

	for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] cv;
		logic [63:0] cr;
		logic        cok;
		logic [63:0] trial;

		if (j == 0) begin : g_first
			assign cv = in_value;
			assign cr = '0;
			assign cok = in_valid;
		end else begin : g_next
			assign cv = v_s[j];
			assign cr = r_s[j];
			assign cok = ok_s[j];
		end

		assign trial = cr + BIT;

		always_ff @(posedge clk) begin
			if (cv >= trial) begin
				v_s[j+1] <= cv - trial;
				r_s[j+1] <= (cr >> 1) + BIT;
			end else begin
				v_s[j+1] <= cv;
				r_s[j+1] <= cr >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ok_s[j+1] <= 1'b0;
			end else begin
				ok_s[j+1] <= cok;
			end
		end
	end

	assign out_valid = ok_s[ISQRT_STEPS];
	assign out_root = r_s[ISQRT_STEPS][31:0];

endmodule

// File: rtl/gcd_back.sv
// Back end: haversine term, square roots, arctangent and scaling to meters.
// Depends on gcd_pkg, gcd_cordic and gcd_isqrt.
module gcd_back
	import gcd_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  queue_status_t       status,
	input  queue_item_t         pop_item,
	output logic                pop,
	input  logic [RADIUS_W-1:0] radius,
	output logic                done,
	output logic [DIST_W-1:0]   distance_m
);

	localparam int XW = FRAC_BITS + 3;
	localparam int MW = FRAC_BITS + 3;
	localparam int AW = FRAC_BITS + 1;
	localparam int SH = 62 - FRAC_BITS;
	localparam logic [63:0] GAIN = gain_inv(CORDIC_STEPS, FRAC_BITS);
	localparam logic signed [XW-1:0] K0 = signed'(XW'(GAIN));
	localparam logic [MW:0] ONE = (MW + 1)'(1) << FRAC_BITS;

	logic               valid_s1;
	logic signed [63:0] z_dlat_s1;
	logic signed [63:0] z_dlon_s1;
	logic signed [63:0] z_la_s1;
	logic signed [63:0] z_lb_s1;

	logic                 rot_valid;
	logic signed [XW-1:0] s1_y;
	logic signed [XW-1:0] s2_y;
	logic signed [XW-1:0] ca_x;
	logic signed [XW-1:0] cb_x;

	logic          valid_s2;
	logic [MW-1:0] sq1_s2;
	logic [MW-1:0] sq2_s2;
	logic [MW-1:0] cc_s2;
	logic          valid_s3;
	logic [MW-1:0] sq1_s3;
	logic [MW-1:0] t_s3;
	logic          valid_s4;
	logic [AW-1:0] a_s4;
	logic [AW-1:0] b_s4;
	logic [MW:0]   a_sum;

	logic        sqa_valid;
	logic [31:0] sqa_root;
	logic [31:0] sqb_root;

	logic                    vec_valid;
	logic signed [63:0]      vec_z;
	logic signed [63:0]      z_clamped;
	logic [63:0]             zq_sum;
	logic                    valid_s5;
	logic [ZQ_W-1:0]         zq_s5;
	logic [57:0]             dist_sum;
	logic                    valid_s6;
	logic [DIST_W-1:0]       dist_s6;

	function automatic logic [MW-1:0] mulq(input logic [MW-1:0] a, input logic [MW-1:0] b);
		logic [2*MW-1:0] p;
		p = a * b + ((2 * MW)'(1) << (FRAC_BITS - 1));
		return MW'(p >> FRAC_BITS);
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] v);
		return (v < 0) ? MW'(unsigned'(-v)) : MW'(unsigned'(v));
	endfunction

	function automatic logic [MW-1:0] pos_part(input logic signed [XW-1:0] v);
		return (v < 0) ? '0 : MW'(unsigned'(v));
	endfunction

	assign pop = !status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= rot_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= vec_valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		z_dlat_s1 <= 64'(pop_item.dlat) * PI_Q28;
		z_dlon_s1 <= 64'(pop_item.dlon) * PI_Q28;
		z_la_s1 <= (64'(pop_item.lat_a) <<< 1) * PI_Q28;
		z_lb_s1 <= (64'(pop_item.lat_b) <<< 1) * PI_Q28;
	end

	gcd_cordic #(.STEPS(CORDIC_STEPS), .XW(XW), .VECTORING(1'b0)) u_rot_dlat (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s1), .in_x(K0), .in_y('0),
		.in_z(z_dlat_s1), .out_valid(rot_valid), .out_x(), .out_y(s1_y), .out_z()
	);

	gcd_cordic #(.STEPS(CORDIC_STEPS), .XW(XW), .VECTORING(1'b0)) u_rot_dlon (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s1), .in_x(K0), .in_y('0),
		.in_z(z_dlon_s1), .out_valid(), .out_x(), .out_y(s2_y), .out_z()
	);

	gcd_cordic #(.STEPS(CORDIC_STEPS), .XW(XW), .VECTORING(1'b0)) u_rot_la (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s1), .in_x(K0), .in_y('0),
		.in_z(z_la_s1), .out_valid(), .out_x(ca_x), .out_y(), .out_z()
	);

	gcd_cordic #(.STEPS(CORDIC_STEPS), .XW(XW), .VECTORING(1'b0)) u_rot_lb (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s1), .in_x(K0), .in_y('0),
		.in_z(z_lb_s1), .out_valid(), .out_x(cb_x), .out_y(), .out_z()
	);

	always_ff @(posedge clk) begin
		sq1_s2 <= mulq(mag(s1_y), mag(s1_y));
		sq2_s2 <= mulq(mag(s2_y), mag(s2_y));
		cc_s2 <= mulq(pos_part(ca_x), pos_part(cb_x));
		sq1_s3 <= sq1_s2;
		t_s3 <= mulq(cc_s2, sq2_s2);
	end

	assign a_sum = {1'b0, sq1_s3} + {1'b0, t_s3};

	always_ff @(posedge clk) begin
		if (a_sum > ONE) begin
			a_s4 <= AW'(ONE);
			b_s4 <= '0;
		end else begin
			a_s4 <= AW'(a_sum);
			b_s4 <= AW'(ONE - a_sum);
		end
	end

	gcd_isqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.in_value(64'(a_s4) << SH), .out_valid(sqa_valid), .out_root(sqa_root)
	);

	gcd_isqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.in_value(64'(b_s4) << SH), .out_valid(), .out_root(sqb_root)
	);

	gcd_cordic #(.STEPS(CORDIC_STEPS), .XW(VEC_W), .VECTORING(1'b1)) u_vec (
		.clk(clk), .arst_n(arst_n), .in_valid(sqa_valid),
		.in_x(signed'(VEC_W'(sqb_root))), .in_y(signed'(VEC_W'(sqa_root))),
		.in_z('0), .out_valid(vec_valid), .out_x(), .out_y(), .out_z(vec_z)
	);

	always_comb begin
		if (vec_z < 0) begin
			z_clamped = '0;
		end else if (vec_z > HALF_PI_Q60) begin
			z_clamped = HALF_PI_Q60;
		end else begin
			z_clamped = vec_z;
		end
	end

	assign zq_sum = unsigned'(z_clamped) + (64'd1 << 27);

	always_ff @(posedge clk) begin
		zq_s5 <= zq_sum[28 +: ZQ_W];
	end

	assign dist_sum = ((58'(radius) * 58'(zq_s5)) << 1) + (58'd1 << 31);

	always_ff @(posedge clk) begin
		dist_s6 <= dist_sum[32 +: DIST_W];
	end

	assign done = valid_s6;
	assign distance_m = dist_s6;

endmodule
